// ===== rtl/vgbs_pkg.sv =====
// Package for the vector grid bilinear sampler.
// Holds grid geometry, field widths, register indexes and the sequencer states.
// Used by the top level; no dependencies.
package vgbs_pkg;

	localparam int MAX_COLS   = 64;
	localparam int MAX_ROWS   = 64;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int AXIS_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
	localparam int WORD_W     = 32;
	localparam int SIZE_W     = 7;
	localparam int CFG_AW     = 5;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 32;
	localparam int WEIGHT_W   = 17;
	localparam int ACC_W      = 50;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [2:0] REG_X_LOW   = 3'd0;
	localparam logic [2:0] REG_X_HIGH  = 3'd1;
	localparam logic [2:0] REG_Y_LOW   = 3'd2;
	localparam logic [2:0] REG_Y_HIGH  = 3'd3;
	localparam logic [2:0] REG_X_SCALE = 3'd4;
	localparam logic [2:0] REG_Y_SCALE = 3'd5;
	localparam logic [2:0] REG_WIDTH   = 3'd6;
	localparam logic [2:0] REG_HEIGHT  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MULX,
		ST_MULY,
		ST_MAPY,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/vgbs_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module vgbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/vector_grid_bilinear_sampler_unit.sv =====
// Top level of the vector grid bilinear sampler: APB registers, sequencer,
// shared mapping multiplier and blend pipeline. Depends on vgbs_pkg and vgbs_ram.
//
// Channel   Direction  Content
// s_*       in         tuser: action; tdata: col, row, value_x, value_y, point_x, point_y
// m_*       out        tuser: inside_res; tdata: out_x, out_y
// APB       in/out     eight configuration registers at byte addresses 0 to 28
//
// A write word needs no sequencer state and the next word may follow at once.
// A query inside the ranges holds the input after acceptance through the range check, two
// products on the shared 32x32 mapping multiplier, four reads of the single grid RAM port and
// a drain of the blend pipeline; a query outside the ranges goes from the check to the result.
// The result waits in an output register; the finished query also waits while it is still full.
// Reset restores the register defaults; grid contents are undefined until written.
module vector_grid_bilinear_sampler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// col[5:0], row[11:6], value_x[27:12], value_y[43:28], point_x[75:44],
	// point_y[107:76], zero pad[111:108]
	input  logic [vgbs_pkg::IN_DATA_W-1:0]   s_tdata,
	// action[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_x[15:0], out_y[31:16]
	output logic [vgbs_pkg::OUT_DATA_W-1:0]  m_tdata,
	// inside_res[0]
	output logic                             m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [vgbs_pkg::CFG_AW-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic signed [31:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic [31:0] x_scale_q, y_scale_q;
	logic [vgbs_pkg::SIZE_W-1:0] width_q, height_q;
	logic [vgbs_pkg::SIZE_W-1:0] w_eff, h_eff;
	logic cfg_wr;

	vgbs_pkg::state_t state_q, state_d;
	logic [1:0] cnt_q;
	logic in_accept, ram_we, load_out;

	logic signed [31:0] px_q, py_q;
	logic inside_q;
	logic [31:0] offx_q, offy_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	logic [vgbs_pkg::SIZE_W-1:0] map_n;
	logic [47:0] map_g, map_top;
	logic [21:0] map_gc;
	logic [vgbs_pkg::AXIS_W-1:0] map_cell;
	logic [vgbs_pkg::WEIGHT_W-1:0] map_wt;

	logic [vgbs_pkg::AXIS_W-1:0] cellx_q, celly_q, rd_x, rd_y;
	logic [vgbs_pkg::WEIGHT_W-1:0] wx_q, wy_q, fx, fy;
	logic [33:0] wgt_full;
	logic [32:0] wgt_s1;
	logic vld_s1, vld_s2;
	logic signed [vgbs_pkg::ACC_W-1:0] prodx_s2, prody_s2, accx_q, accy_q;

	logic [vgbs_pkg::ADDR_W-1:0] wr_addr, rd_addr;
	logic [vgbs_pkg::WORD_W-1:0] wr_data, rd_data;

	logic m_tvalid_q, m_tuser_q;
	logic [15:0] out_x_q, out_y_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q   <= 32'sd0;
			x_high_q  <= 32'sd4128768;
			y_low_q   <= 32'sd0;
			y_high_q  <= 32'sd4128768;
			x_scale_q <= 32'd65536;
			y_scale_q <= 32'd65536;
			width_q   <= 7'd64;
			height_q  <= 7'd64;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				vgbs_pkg::REG_X_LOW:   x_low_q   <= pwdata;
				vgbs_pkg::REG_X_HIGH:  x_high_q  <= pwdata;
				vgbs_pkg::REG_Y_LOW:   y_low_q   <= pwdata;
				vgbs_pkg::REG_Y_HIGH:  y_high_q  <= pwdata;
				vgbs_pkg::REG_X_SCALE: x_scale_q <= pwdata;
				vgbs_pkg::REG_Y_SCALE: y_scale_q <= pwdata;
				vgbs_pkg::REG_WIDTH:   width_q   <= pwdata[vgbs_pkg::SIZE_W-1:0];
				vgbs_pkg::REG_HEIGHT:  height_q  <= pwdata[vgbs_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			vgbs_pkg::REG_X_LOW:   prdata = x_low_q;
			vgbs_pkg::REG_X_HIGH:  prdata = x_high_q;
			vgbs_pkg::REG_Y_LOW:   prdata = y_low_q;
			vgbs_pkg::REG_Y_HIGH:  prdata = y_high_q;
			vgbs_pkg::REG_X_SCALE: prdata = x_scale_q;
			vgbs_pkg::REG_Y_SCALE: prdata = y_scale_q;
			vgbs_pkg::REG_WIDTH:   prdata = 32'(width_q);
			vgbs_pkg::REG_HEIGHT:  prdata = 32'(height_q);
			default:               prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (width_q < 7'd2) begin
			w_eff = 7'd2;
		end else if (width_q > 7'(vgbs_pkg::MAX_COLS)) begin
			w_eff = 7'(vgbs_pkg::MAX_COLS);
		end else begin
			w_eff = width_q;
		end
		if (height_q < 7'd2) begin
			h_eff = 7'd2;
		end else if (height_q > 7'(vgbs_pkg::MAX_ROWS)) begin
			h_eff = 7'(vgbs_pkg::MAX_ROWS);
		end else begin
			h_eff = height_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vgbs_pkg::ST_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= 2'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		in_accept = 1'b0;
		case (state_q)
			vgbs_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				in_accept = s_tvalid;
				if (s_tvalid && s_tuser == vgbs_pkg::ACT_WRITE) begin
					ram_we = 1'b1;
				end
				if (s_tvalid && s_tuser == vgbs_pkg::ACT_QUERY) begin
					state_d = vgbs_pkg::ST_CHECK;
				end
			end
			vgbs_pkg::ST_CHECK: begin
				if (px_q < x_low_q || px_q > x_high_q || py_q < y_low_q || py_q > y_high_q) begin
					state_d = vgbs_pkg::ST_DONE;
				end else begin
					state_d = vgbs_pkg::ST_MULX;
				end
			end
			vgbs_pkg::ST_MULX: state_d = vgbs_pkg::ST_MULY;
			vgbs_pkg::ST_MULY: state_d = vgbs_pkg::ST_MAPY;
			vgbs_pkg::ST_MAPY: state_d = vgbs_pkg::ST_READ;
			vgbs_pkg::ST_READ: begin
				if (cnt_q == 2'd3) begin
					state_d = vgbs_pkg::ST_DRAIN;
				end
			end
			vgbs_pkg::ST_DRAIN: begin
				if (cnt_q == 2'd1) begin
					state_d = vgbs_pkg::ST_DONE;
				end
			end
			vgbs_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = vgbs_pkg::ST_IDLE;
				end
			end
			default: state_d = vgbs_pkg::ST_IDLE;
		endcase
	end

	// Mapping of an offset onto a cell index and a Q1.16 weight.
	assign mul_a = (state_q == vgbs_pkg::ST_MULX) ? offx_q : offy_q;
	assign mul_b = (state_q == vgbs_pkg::ST_MULX) ? x_scale_q : y_scale_q;
	assign map_n = (state_q == vgbs_pkg::ST_MULY) ? w_eff : h_eff;
	assign map_g = prod_q[63:16];
	assign map_top = 48'(map_n - 7'd1) << 16;
	assign map_gc = (map_g > map_top) ? map_top[21:0] : map_g[21:0];

	always_comb begin
		if ({1'b0, map_gc[21:16]} > (map_n - 7'd2)) begin
			map_cell = vgbs_pkg::AXIS_W'(map_n - 7'd2);
			map_wt   = vgbs_pkg::WEIGHT_ONE;
		end else begin
			map_cell = vgbs_pkg::AXIS_W'(map_gc[21:16]);
			map_wt   = {1'b0, map_gc[15:0]};
		end
	end

	// Corner k: bit 0 selects the right column, bit 1 the lower row.
	assign rd_x = cellx_q + vgbs_pkg::AXIS_W'(cnt_q[0]);
	assign rd_y = celly_q + vgbs_pkg::AXIS_W'(cnt_q[1]);
	assign rd_addr = {rd_y[vgbs_pkg::ROW_W-1:0], rd_x[vgbs_pkg::COL_W-1:0]};
	assign fx = cnt_q[0] ? wx_q : (vgbs_pkg::WEIGHT_ONE - wx_q);
	assign fy = cnt_q[1] ? wy_q : (vgbs_pkg::WEIGHT_ONE - wy_q);
	assign wgt_full = fx * fy;

	assign wr_addr = {s_tdata[6 +: vgbs_pkg::ROW_W], s_tdata[0 +: vgbs_pkg::COL_W]};
	assign wr_data = {s_tdata[43:28], s_tdata[27:12]};

	vgbs_ram #(
		.WIDTH(vgbs_pkg::WORD_W),
		.DEPTH(vgbs_pkg::GRID_DEPTH)
	) u_grid (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Datapath.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q <= s_tdata[75:44];
			py_q <= s_tdata[107:76];
		end
		if (state_q == vgbs_pkg::ST_CHECK) begin
			offx_q <= px_q - x_low_q;
			offy_q <= py_q - y_low_q;
		end
		if (state_q == vgbs_pkg::ST_MULX || state_q == vgbs_pkg::ST_MULY) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == vgbs_pkg::ST_MULY) begin
			cellx_q <= map_cell;
			wx_q    <= map_wt;
		end
		if (state_q == vgbs_pkg::ST_MAPY) begin
			celly_q <= map_cell;
			wy_q    <= map_wt;
		end
		wgt_s1   <= wgt_full[32:0];
		prodx_s2 <= $signed(rd_data[15:0]) * $signed({1'b0, wgt_s1});
		prody_s2 <= $signed(rd_data[31:16]) * $signed({1'b0, wgt_s1});
		if (state_q == vgbs_pkg::ST_MAPY) begin
			accx_q <= '0;
			accy_q <= '0;
		end else if (vld_s2) begin
			accx_q <= accx_q + prodx_s2;
			accy_q <= accy_q + prody_s2;
		end
		if (load_out) begin
			out_x_q <= inside_q ? accx_q[47:32] : 16'd0;
			out_y_q <= inside_q ? accy_q[47:32] : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (state_q == vgbs_pkg::ST_CHECK) begin
				inside_q <= (state_d == vgbs_pkg::ST_MULX);
			end
			vld_s1 <= (state_q == vgbs_pkg::ST_READ);
			vld_s2 <= vld_s1;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				m_tuser_q  <= inside_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = {out_y_q, out_x_q};

`ifndef NO_ASSERTIONS
	ast_ram_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == vgbs_pkg::ST_IDLE))
		else $error("grid written outside idle");

	ast_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vgbs_pkg::ST_DONE) |-> (!vld_s1 && !vld_s2))
		else $error("blend pipeline not drained at result");

	ast_cell_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vgbs_pkg::ST_READ) |->
		({1'b0, cellx_q} <= (w_eff - 7'd2) && {1'b0, celly_q} <= (h_eff - 7'd2)))
		else $error("cell index beyond used grid");

	ast_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vgbs_pkg::ST_READ) |->
		(wx_q <= vgbs_pkg::WEIGHT_ONE && wy_q <= vgbs_pkg::WEIGHT_ONE))
		else $error("weight above one");

	ast_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == vgbs_pkg::ST_DONE))
		else $error("result word without finished query");
`endif

endmodule

// ===== tb/tb_vector_grid_bilinear_sampler_unit.sv =====
// Self-checking testbench for vector_grid_bilinear_sampler_unit.
// Drives grid loads and query points through the stream ports and the registers over APB.
// A scoreboard class predicts each blended sample. Depends on vgbs_pkg and the RTL only.
module tb_vector_grid_bilinear_sampler_unit;
	import vgbs_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_WORDS   = 120;
	localparam int PHASES        = 10;
	localparam longint Q_MIN     = -64'sd2147483648;
	localparam longint Q_MAX     = 64'sd2147483647;

	typedef struct packed {
		logic [3:0]  pad;
		logic [31:0] point_y;
		logic [31:0] point_x;
		logic [15:0] value_y;
		logic [15:0] value_x;
		logic [5:0]  row;
		logic [5:0]  col;
	} in_word_t;

	typedef struct packed {
		logic [15:0] vx;
		logic [15:0] vy;
		logic        in_range;
	} sample_t;

	class sample_checker;
		logic signed [31:0] x_lo, x_hi, y_lo, y_hi;
		logic [31:0]        x_scl, y_scl;
		logic [SIZE_W-1:0]  cols, rows;
		logic [WORD_W-1:0]  grid_mem [GRID_DEPTH];
		bit                 seen [GRID_DEPTH];
		sample_t            pending_samples [$];
		int                 fail_count;

		function new();
			x_lo = 32'h0;
			x_hi = 32'h003F0000;
			y_lo = 32'h0;
			y_hi = 32'h003F0000;
			x_scl = 32'h00010000;
			y_scl = 32'h00010000;
			cols = 7'd64;
			rows = 7'd64;
			fail_count = 0;
		endfunction

		task flag_mismatch(input string msg);
			$display("mismatch: %s", msg);
			fail_count++;
		endtask

		function void set_reg(input logic [2:0] idx, input logic [31:0] value);
			case (idx)
			REG_X_LOW:   x_lo = value;
			REG_X_HIGH:  x_hi = value;
			REG_Y_LOW:   y_lo = value;
			REG_Y_HIGH:  y_hi = value;
			REG_X_SCALE: x_scl = value;
			REG_Y_SCALE: y_scl = value;
			REG_WIDTH:   cols = value[SIZE_W-1:0];
			default:     rows = value[SIZE_W-1:0];
			endcase
		endfunction

		function int grid_size(input logic [SIZE_W-1:0] n, input int limit);
			if (n < 2)
				return 2;
			if (n > limit)
				return limit;
			return int'(n);
		endfunction

		function void map_axis(input bit [63:0] offset, input bit [31:0] scale, input int n,
				output int ci, output int wt);
			bit [63:0] g;
			bit [63:0] top;
			g = (offset * 64'(scale)) >> 16;
			top = 64'(n - 1) << 16;
			if (g > top)
				g = top;
			ci = int'(g >> 16);
			wt = int'(g[15:0]);
			if (ci > n - 2) begin
				ci = n - 2;
				wt = 65536;
			end
		endfunction

		function void locate(input logic signed [31:0] px, input logic signed [31:0] py,
				output bit hit, output int ix, output int iy, output int tx, output int ty);
			hit = !(px < x_lo || px > x_hi || py < y_lo || py > y_hi);
			ix = 0;
			iy = 0;
			tx = 0;
			ty = 0;
			if (hit) begin
				map_axis(64'(longint'(px) - longint'(x_lo)), x_scl, grid_size(cols, MAX_COLS),
					ix, tx);
				map_axis(64'(longint'(py) - longint'(y_lo)), y_scl, grid_size(rows, MAX_ROWS),
					iy, ty);
			end
		endfunction

		function logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
				input logic [15:0] c, input logic [15:0] d, input int wx, input int wy);
			longint r1, r2, r;
			r1 = longint'($signed(a)) * (65536 - wx) + longint'($signed(b)) * wx;
			r2 = longint'($signed(c)) * (65536 - wx) + longint'($signed(d)) * wx;
			r = r1 * (65536 - wy) + r2 * wy;
			r = r >>> 32;
			return r[15:0];
		endfunction

		function sample_t predict_sample(input logic [31:0] px, input logic [31:0] py);
			sample_t s;
			bit hit;
			int ix, iy, tx, ty;
			logic [31:0] a, b, c, d;
			locate(px, py, hit, ix, iy, tx, ty);
			s = '0;
			if (hit) begin
				a = grid_mem[iy * MAX_COLS + ix];
				b = grid_mem[iy * MAX_COLS + ix + 1];
				c = grid_mem[(iy + 1) * MAX_COLS + ix];
				d = grid_mem[(iy + 1) * MAX_COLS + ix + 1];
				s.vx = blend(a[15:0], b[15:0], c[15:0], d[15:0], tx, ty);
				s.vy = blend(a[31:16], b[31:16], c[31:16], d[31:16], tx, ty);
				s.in_range = 1'b1;
			end
			return s;
		endfunction

		function void note_word(input logic act, input in_word_t w);
			if (act == ACT_WRITE) begin
				grid_mem[w.row * MAX_COLS + w.col] = {w.value_y, w.value_x};
				seen[w.row * MAX_COLS + w.col] = 1'b1;
			end else begin
				pending_samples.push_back(predict_sample(w.point_x, w.point_y));
			end
		endfunction

		task check_word(input logic [31:0] data, input logic flag);
			sample_t want;
			if (pending_samples.size() == 0) begin
				flag_mismatch($sformatf("unexpected word %h inside %b", data, flag));
				return;
			end
			want = pending_samples.pop_front();
			if (data[15:0] !== want.vx)
				flag_mismatch($sformatf("out_x %h, expected %h", data[15:0], want.vx));
			if (data[31:16] !== want.vy)
				flag_mismatch($sformatf("out_y %h, expected %h", data[31:16], want.vy));
			if (flag !== want.in_range)
				flag_mismatch($sformatf("inside_res %b, expected %b", flag, want.in_range));
		endtask

		function int pending();
			return pending_samples.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_AW-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	sample_checker sb = new();
	int gap_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	vector_grid_bilinear_sampler_unit dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("vector_grid_bilinear_sampler_unit regression: fail");
			$finish;
		end
	end

	task automatic push_word(input logic act, input in_word_t w);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_word(act, w);
	endtask

	task automatic put_entry(input logic [5:0] col, input logic [5:0] row,
			input logic [15:0] vx, input logic [15:0] vy);
		in_word_t w;
		w.pad = '0;
		w.point_x = $urandom;
		w.point_y = $urandom;
		w.col = col;
		w.row = row;
		w.value_x = vx;
		w.value_y = vy;
		push_word(ACT_WRITE, w);
	endtask

	// Any of the four neighbors not loaded yet is written first, so no query
	// ever reads an uninitialized grid location.
	task automatic ask(input logic [31:0] px, input logic [31:0] py);
		in_word_t w;
		bit hit;
		int ix, iy, tx, ty;
		sb.locate(px, py, hit, ix, iy, tx, ty);
		if (hit) begin
			for (int k = 0; k < 4; k++) begin
				if (!sb.seen[(iy + k / 2) * MAX_COLS + ix + k % 2])
					put_entry(6'(ix + k % 2), 6'(iy + k / 2), 16'($urandom), 16'($urandom));
			end
		end
		w.pad = '0;
		w.col = 6'($urandom);
		w.row = 6'($urandom);
		w.value_x = 16'($urandom);
		w.value_y = 16'($urandom);
		w.point_x = px;
		w.point_y = py;
		push_word(ACT_QUERY, w);
	endtask

	task automatic wait_for_results(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		want = (idx == REG_WIDTH || idx == REG_HEIGHT) ? {25'b0, value[6:0]} : value;
		if (prdata !== want)
			sb.flag_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
	endtask

	task automatic load_config(input logic [31:0] xl, input logic [31:0] xh,
			input logic [31:0] yl, input logic [31:0] yh, input logic [31:0] xs,
			input logic [31:0] ys, input logic [6:0] w, input logic [6:0] h);
		cfg_write(REG_X_LOW, xl);
		cfg_write(REG_X_HIGH, xh);
		cfg_write(REG_Y_LOW, yl);
		cfg_write(REG_Y_HIGH, yh);
		cfg_write(REG_X_SCALE, xs);
		cfg_write(REG_Y_SCALE, ys);
		cfg_write(REG_WIDTH, {25'b0, w});
		cfg_write(REG_HEIGHT, {25'b0, h});
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void pick_range(output logic [31:0] lo, output logic [31:0] hi,
			output longint span);
		longint base;
		span = longint'($urandom_range(1, 32'h00FFFFFF)) << $urandom_range(0, 7);
		base = longint'($signed($urandom));
		if (base + span > Q_MAX)
			base = Q_MAX - span;
		lo = base[31:0];
		hi = 32'(base + span);
	endfunction

	// Scale that maps the whole range onto the grid, sometimes overshooting
	// so that the upper edge saturates.
	function automatic logic [31:0] fit_scale(input int n, input longint span);
		longint s;
		s = (longint'(n - 1) << 32) / span;
		if ($urandom_range(0, 3) == 0)
			s = s + (s >> 3);
		if (s > 32'hFFFFFFFF)
			s = 32'hFFFFFFFF;
		return s[31:0];
	endfunction

	task automatic random_config(input bit full_grid);
		logic [31:0] xl, xh, yl, yh;
		longint xspan, yspan;
		int w, h;
		pick_range(xl, xh, xspan);
		pick_range(yl, yh, yspan);
		if (full_grid) begin
			w = MAX_COLS;
			h = MAX_ROWS;
		end else begin
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, MAX_COLS) : $urandom_range(2, 8);
			h = ($urandom_range(0, 5) == 0) ? $urandom_range(9, MAX_ROWS) : $urandom_range(2, 8);
		end
		load_config(xl, xh, yl, yh, fit_scale(w, xspan), fit_scale(h, yspan), 7'(w), 7'(h));
	endtask

	function automatic logic [31:0] point_within(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		longint span;
		span = longint'(hi) - longint'(lo);
		if (span < 0)
			return $urandom;
		case ($urandom_range(0, 9))
		0:       return lo;
		1:       return hi;
		default: return 32'(longint'(lo) + longint'({$urandom, $urandom} % (span + 1)));
		endcase
	endfunction

	function automatic logic [31:0] point_beyond(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		longint v;
		bit low_side;
		low_side = $urandom_range(0, 1);
		if (longint'(lo) == Q_MIN && longint'(hi) == Q_MAX)
			return $urandom;
		if (longint'(lo) == Q_MIN)
			low_side = 1'b0;
		if (longint'(hi) == Q_MAX)
			low_side = 1'b1;
		if (low_side) begin
			v = longint'(lo) - 1 - longint'($urandom_range(0, 4095));
			if (v < Q_MIN)
				v = Q_MIN;
		end else begin
			v = longint'(hi) + 1 + longint'($urandom_range(0, 4095));
			if (v > Q_MAX)
				v = Q_MAX;
		end
		return v[31:0];
	endfunction

	// Mostly in-range queries with their neighbors loaded on demand, plus
	// loose grid loads, out-of-range points and raw random points.
	task automatic random_item();
		int pick;
		logic [31:0] px, py;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			ask(point_within(sb.x_lo, sb.x_hi), point_within(sb.y_lo, sb.y_hi));
		end else if (pick < 75) begin
			if ($urandom_range(0, 1))
				put_entry(6'($urandom_range(0, sb.grid_size(sb.cols, MAX_COLS) - 1)),
					6'($urandom_range(0, sb.grid_size(sb.rows, MAX_ROWS) - 1)),
					16'($urandom), 16'($urandom));
			else
				put_entry(6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
		end else if (pick < 90) begin
			case ($urandom_range(0, 2))
			0: begin
				px = point_beyond(sb.x_lo, sb.x_hi);
				py = point_within(sb.y_lo, sb.y_hi);
			end
			1: begin
				px = point_within(sb.x_lo, sb.x_hi);
				py = point_beyond(sb.y_lo, sb.y_hi);
			end
			default: begin
				px = point_beyond(sb.x_lo, sb.x_hi);
				py = point_beyond(sb.y_lo, sb.y_hi);
			end
			endcase
			ask(px, py);
		end else begin
			ask($urandom, $urandom);
		end
	endtask

	task automatic directed_items();
		put_entry(6'd0, 6'd0, 16'h7FFF, 16'h8000);
		put_entry(6'd1, 6'd0, 16'h8000, 16'h7FFF);
		put_entry(6'd0, 6'd1, 16'h0000, 16'hFFFF);
		put_entry(6'd1, 6'd1, 16'hFFFF, 16'h0001);
		ask(32'h0, 32'h0);
		ask(32'h00008000, 32'h00008000);
		ask(32'h00010000, 32'h00010000);
		ask(32'h00004000, 32'h0000C000);
		put_entry(6'd63, 6'd63, 16'h7FFF, 16'h7FFF);
		put_entry(6'd62, 6'd63, 16'h8000, 16'h8000);
		ask(32'h003F0000, 32'h003F0000);
		ask(32'h003EC000, 32'h003F0000);
		ask(32'h001F8000, 32'h000C4000);
		ask(32'hFFFFFFFF, 32'h0);
		ask(32'h0, 32'hFFFFFFFF);
		ask(32'h003F0001, 32'h0);
		ask(32'h0, 32'h003F0001);
		ask(32'h80000000, 32'h80000000);
		ask(32'h7FFFFFFF, 32'h7FFFFFFF);
	endtask

	task automatic configure(input int phase);
		case (phase)
		1: load_config(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'hFFFFFFFF, 32'h00000000, 7'd0, 7'd127);
		2: load_config(32'h00640000, 32'hFFFF0000, 32'h00000000, 32'h00010000,
			32'h00010000, 32'h00010000, 7'd1, 7'd65);
		3: load_config(32'h12345678, 32'h12345678, 32'hFFF00000, 32'h00100000,
			32'h00000000, 32'h00080000, 7'd2, 7'd2);
		PHASES - 1: random_config(1'b1);
		default: random_config(1'b0);
		endcase
	endtask

	task automatic run_phase(input int phase, input int count);
		for (int k = 0; k < count; k++) begin
			case ((k * 4 / count + phase) % 4)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct = 81;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 81;
			end
			default: begin
				gap_pct = 14;
				stall_pct = 14;
			end
			endcase
			if (k == count / 2)
				wait_for_results(0);
			random_item();
		end
		wait_for_results(SETTLE_CYCLES);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				configure(p);
			run_phase(p, PHASE_WORDS);
		end
		if (sb.fail_count == 0)
			$display("vector_grid_bilinear_sampler_unit regression: pass");
		else
			$display("vector_grid_bilinear_sampler_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vgbs_pkg.sv
rtl/vgbs_ram.sv
rtl/vector_grid_bilinear_sampler_unit.sv
tb/tb_vector_grid_bilinear_sampler_unit.sv
